FILE: rtl/ledr_pkg.sv
package ledr_pkg;

  // default ring capacity
  localparam int MAX_LEDS_DEFAULT = 64;
  // fixed by the 6-bit pixel index and position
  localparam int RING_LIMIT = 64;

  // operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SET  = 1'b1;

  // animation modes
  localparam logic [1:0] MODE_SOLID = 2'd0;
  localparam logic [1:0] MODE_FLASH = 2'd1;
  localparam logic [1:0] MODE_PULSE = 2'd2;
  localparam logic [1:0] MODE_CHASE = 2'd3;

  // configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 24;
  localparam logic [CFG_INDEX_W-1:0] CFG_BACKGROUND = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LED_COUNT  = 1'd1;

  // animation constants
  localparam logic [7:0] PULSE_STEPS = 8'd200;
  localparam logic [7:0] PULSE_HALF  = 8'd100;
  localparam logic [7:0] PULSE_FLOOR = 8'd55;
  localparam logic [7:0] FULL_BRIGHT = 8'd255;
  localparam logic [7:0] CHASE_TAIL  = 8'd3;
  localparam logic [6:0] RING_MIN    = 7'd3;
  localparam logic [6:0] LED_COUNT_RESET = 7'd12;

  // period / 200 = (period >> 3) / 25, with /25 as multiply by 5243 >> 17
  localparam int          PULSE_PRE_SHIFT = 3;
  localparam logic [12:0] PULSE_RECIP     = 13'd5243;
  localparam int          PULSE_SHIFT     = 17;

  typedef struct packed {
    logic        operation;
    logic [1:0]  mode;
    logic [23:0] color;
    logic [15:0] period;
    logic [15:0] duration;
  } in_item_t;

  typedef struct packed {
    logic        fill_all;
    logic [5:0]  pixel_index;
    logic [23:0] pixel_color;
    logic        set_brightness;
    logic [7:0]  brightness;
    logic        last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic set_apply;
    logic tick_inc;
    logic expire_chk;
    logic evaluate;
    logic solid_emit;
    logic flash_emit;
    logic pulse_emit;
    logic chase_start;
    logic chase_reduce;
    logic chase_bg;
    logic chase_head;
  } ledr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       new_is_set;
    logic       set_solid;
    logic       fire;
    logic [1:0] act_mode;
    logic       mod_done;
    logic       slot_free;
  } ledr_status_t;

endpackage

FILE: rtl/ledr_ctrl.sv
module ledr_ctrl
  import ledr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  ledr_status_t status,
  output ledr_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SET     = 4'd1;
  localparam logic [3:0] S_SOLID   = 4'd2;
  localparam logic [3:0] S_TICK    = 4'd3;
  localparam logic [3:0] S_EXPIRE  = 4'd4;
  localparam logic [3:0] S_EVAL    = 4'd5;
  localparam logic [3:0] S_DECIDE  = 4'd6;
  localparam logic [3:0] S_FLASH   = 4'd7;
  localparam logic [3:0] S_PULSE   = 4'd8;
  localparam logic [3:0] S_CH_INC  = 4'd9;
  localparam logic [3:0] S_CH_MOD  = 4'd10;
  localparam logic [3:0] S_CH_BG   = 4'd11;
  localparam logic [3:0] S_CH_HEAD = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = status.new_is_set ? S_SET : S_TICK;
        end
      end
      S_SET: begin
        cmd.set_apply = 1'b1;
        state_next    = status.set_solid ? S_SOLID : S_IDLE;
      end
      S_SOLID: begin
        if (status.slot_free) begin
          cmd.solid_emit = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_TICK: begin
        cmd.tick_inc = 1'b1;
        state_next   = S_EXPIRE;
      end
      S_EXPIRE: begin
        cmd.expire_chk = 1'b1;
        state_next     = S_EVAL;
      end
      S_EVAL: begin
        cmd.evaluate = 1'b1;
        state_next   = S_DECIDE;
      end
      S_DECIDE: begin
        state_next = S_IDLE;
        if (status.fire) begin
          unique case (status.act_mode)
            MODE_FLASH: state_next = S_FLASH;
            MODE_PULSE: state_next = S_PULSE;
            MODE_CHASE: state_next = S_CH_INC;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_FLASH: begin
        if (status.slot_free) begin
          cmd.flash_emit = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_PULSE: begin
        if (status.slot_free) begin
          cmd.pulse_emit = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_CH_INC: begin
        cmd.chase_start = 1'b1;
        state_next      = S_CH_MOD;
      end
      S_CH_MOD: begin
        cmd.chase_reduce = 1'b1;
        if (status.mod_done) begin
          state_next = S_CH_BG;
        end
      end
      S_CH_BG: begin
        if (status.slot_free) begin
          cmd.chase_bg = 1'b1;
          state_next   = S_CH_HEAD;
        end
      end
      S_CH_HEAD: begin
        if (status.slot_free) begin
          cmd.chase_head = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/ledr_dp.sv
module ledr_dp
  import ledr_pkg::*;
#(
  parameter int MAX_LEDS = MAX_LEDS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  ledr_cmd_t              cmd,
  output ledr_status_t           status
);

  localparam int RING_MAX = (MAX_LEDS < RING_LIMIT) ? MAX_LEDS : RING_LIMIT;

  // configuration
  logic [23:0] background_color;
  logic [6:0]  led_count;

  // animation state
  logic [31:0] time_now;
  logic [31:0] last_change_time;
  logic        override_active;
  logic [1:0]  override_mode;
  logic [23:0] override_color;
  logic [15:0] override_period;
  logic [15:0] override_length;
  logic [31:0] override_start;
  logic [1:0]  base_mode;
  logic [23:0] base_color;
  logic [15:0] base_period;
  logic        flash_phase;
  logic [7:0]  pulse_step;
  logic [5:0]  chase_position;

  // working registers
  in_item_t    item;
  logic [1:0]  act_mode;
  logic [23:0] act_color;
  logic [15:0] act_period;
  logic [31:0] elapsed;
  logic [25:0] pulse_prod;
  logic [6:0]  ring_n;
  logic [6:0]  chase_work;

  // combinational helpers
  logic [6:0]  ring_calc;
  logic [15:0] sel_period;
  logic [15:0] threshold;
  logic [31:0] ovr_age;
  logic [7:0]  tri_level;
  logic [7:0]  pulse_bright;
  logic [7:0]  tail_raw;
  logic [7:0]  tail;
  logic [5:0]  tail_index;
  logic [5:0]  head_index;
  logic        slot_free;
  out_item_t   emit_item;
  logic        emit;

  // ring size with clamping
  always_comb begin
    ring_calc = led_count;
    if (ring_calc < RING_MIN) ring_calc = RING_MIN;
    if (ring_calc > 7'(RING_MAX)) ring_calc = 7'(RING_MAX);
  end

  assign sel_period = override_active ? override_period : base_period;
  assign ovr_age    = time_now - override_start;
  assign threshold  = (act_mode == MODE_PULSE) ?
                      16'(pulse_prod[25:PULSE_SHIFT]) : act_period;

  // pulse triangle
  assign tri_level    = (pulse_step < PULSE_HALF) ? pulse_step : (PULSE_STEPS - pulse_step);
  assign pulse_bright = {tri_level[6:0], 1'b0} + PULSE_FLOOR;

  // chase tail three behind the head, position already below ring size
  assign tail_raw   = {2'b00, chase_position} + {1'b0, ring_n} - CHASE_TAIL;
  assign tail       = (tail_raw >= {1'b0, ring_n}) ? (tail_raw - {1'b0, ring_n}) : tail_raw;
  assign tail_index = 6'(ring_n - 7'd1 - tail[6:0]);
  assign head_index = 6'(ring_n - 7'd1 - {1'b0, chase_position});

  assign slot_free = !out_valid || out_ready;

  // status to the controller
  assign status.new_is_set = (in_data.operation == OP_SET);
  assign status.set_solid  = (item.mode == MODE_SOLID);
  assign status.fire       = (elapsed > {16'd0, threshold});
  assign status.act_mode   = act_mode;
  assign status.mod_done   = (chase_work < ring_n);
  assign status.slot_free  = slot_free;

  // command to load into the output register
  always_comb begin
    emit_item = '0;
    emit      = cmd.solid_emit | cmd.flash_emit | cmd.pulse_emit |
                cmd.chase_bg | cmd.chase_head;
    priority if (cmd.solid_emit) begin
      emit_item.fill_all    = 1'b1;
      emit_item.pixel_color = item.color;
      emit_item.last        = 1'b1;
    end else if (cmd.flash_emit) begin
      emit_item.fill_all       = 1'b1;
      emit_item.pixel_color    = flash_phase ? background_color : act_color;
      emit_item.set_brightness = 1'b1;
      emit_item.brightness     = FULL_BRIGHT;
      emit_item.last           = 1'b1;
    end else if (cmd.pulse_emit) begin
      emit_item.fill_all       = 1'b1;
      emit_item.pixel_color    = act_color;
      emit_item.set_brightness = 1'b1;
      emit_item.brightness     = pulse_bright;
      emit_item.last           = 1'b1;
    end else if (cmd.chase_bg) begin
      emit_item.pixel_index    = tail_index;
      emit_item.pixel_color    = background_color;
      emit_item.set_brightness = 1'b1;
      emit_item.brightness     = FULL_BRIGHT;
    end else if (cmd.chase_head) begin
      emit_item.pixel_index    = head_index;
      emit_item.pixel_color    = act_color;
      emit_item.set_brightness = 1'b1;
      emit_item.brightness     = FULL_BRIGHT;
      emit_item.last           = 1'b1;
    end else begin
      emit_item = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= emit_item;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_data;
    end
    if (cmd.evaluate) begin
      act_mode   <= override_active ? override_mode : base_mode;
      act_color  <= override_active ? override_color : base_color;
      act_period <= sel_period;
      elapsed    <= time_now - last_change_time;
      pulse_prod <= sel_period[15:PULSE_PRE_SHIFT] * PULSE_RECIP;
      ring_n     <= ring_calc;
    end
    if (cmd.chase_start) begin
      chase_work <= {1'b0, chase_position} + 7'd1;
    end else if (cmd.chase_reduce && !status.mod_done) begin
      chase_work <= chase_work - ring_n;
    end
  end

  // configuration and animation state
  always_ff @(posedge clk) begin
    if (rst) begin
      background_color <= '0;
      led_count        <= LED_COUNT_RESET;
      time_now         <= '0;
      last_change_time <= '0;
      override_active  <= 1'b0;
      override_mode    <= MODE_SOLID;
      override_color   <= '0;
      override_period  <= '0;
      override_length  <= '0;
      override_start   <= '0;
      base_mode        <= MODE_SOLID;
      base_color       <= '0;
      base_period      <= '0;
      flash_phase      <= 1'b0;
      pulse_step       <= '0;
      chase_position   <= '0;
    end else begin
      // register writes
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_BACKGROUND: background_color <= cfg_data[23:0];
          CFG_LED_COUNT:  led_count        <= cfg_data[6:0];
          default:        ;
        endcase
      end

      // set mode: override with nonzero duration, base otherwise
      if (cmd.set_apply) begin
        if (item.duration != 16'd0) begin
          override_active <= 1'b1;
          override_mode   <= item.mode;
          override_length <= item.duration;
          override_start  <= time_now;
          override_color  <= item.color;
          override_period <= item.period;
        end else begin
          base_mode   <= item.mode;
          base_color  <= item.color;
          base_period <= item.period;
        end
      end

      if (cmd.tick_inc) begin
        time_now <= time_now + 32'd1;
      end

      // override expiry
      if (cmd.expire_chk && override_active && (ovr_age > {16'd0, override_length})) begin
        override_active <= 1'b0;
      end

      if (cmd.flash_emit) begin
        last_change_time <= time_now;
        flash_phase      <= ~flash_phase;
      end

      if (cmd.pulse_emit) begin
        last_change_time <= time_now;
        pulse_step       <= (pulse_step == PULSE_STEPS - 8'd1) ? 8'd0 : pulse_step + 8'd1;
      end

      if (cmd.chase_start) begin
        last_change_time <= time_now;
      end

      // head position once reduced below ring size
      if (cmd.chase_reduce && status.mod_done) begin
        chase_position <= chase_work[5:0];
      end
    end
  end

endmodule

FILE: rtl/led_ring_animation_controller.sv
// set mode: capture, then S_SET applies it; a solid mode then loads its fill
//   command in S_SOLID once the output slot is free
// tick: S_TICK, S_EXPIRE, S_EVAL, S_DECIDE; if it fires, S_FLASH/S_PULSE loads
//   the command once the slot is free, and chase reduces the head in S_CH_MOD
//   until it is below the ring size, then S_CH_BG and S_CH_HEAD each load a
//   pixel command once the slot is free; throughput: one item at a time
// reset: synchronous, clears all animation state; led_count returns to 12
module led_ring_animation_controller
  import ledr_pkg::*;
#(
  parameter int MAX_LEDS = MAX_LEDS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  ledr_cmd_t    cmd;
  ledr_status_t status;

  // sequencer
  ledr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // state, arithmetic and output register
  ledr_dp #(
    .MAX_LEDS (MAX_LEDS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

FILE: rtl/ledr_chk.sv
module ledr_chk
  import ledr_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // no result straight out of reset
  a_rst_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

  // only the chase background pixel is a non-final command
  a_non_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last |-> !out_data.fill_all && out_data.set_brightness &&
                                    (out_data.brightness == FULL_BRIGHT))
    else $error("unexpected non-final command");

  // solid fill carries no brightness
  a_solid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.set_brightness |-> out_data.fill_all && out_data.last &&
                                             (out_data.brightness == 8'd0))
    else $error("malformed solid fill");

endmodule

bind led_ring_animation_controller ledr_chk u_ledr_chk (.*);
